FILE: hw/rtl/sjfq_pkg.sv
// Shared types and constants for the shortest-job-first request queue.
package sjfq_pkg;

	localparam int TAG_W   = 16;
	localparam int SIZE_W  = 31;
	localparam int COUNT_W = 5;

	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [SIZE_W-1:0] fsize_t;

	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	localparam logic POLICY_FIFO     = 1'b0;
	localparam logic POLICY_SMALLEST = 1'b1;

	typedef struct packed {
		tag_t   tag;
		fsize_t size;
	} entry_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic   enq;
		logic   deq;
		logic   policy;
		entry_t item;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_BACK,
		OP_FWD
	} cell_op_t;

endpackage

FILE: hw/rtl/sjfq_if.sv
// Request and result channel interfaces (valid/ready with payload).
interface sjfq_req_if;
	import sjfq_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [TAG_W-1:0]  request_tag;
	logic [SIZE_W-1:0] file_size;
	modport source(output valid, kind, request_tag, file_size, input ready);
	modport sink(input valid, kind, request_tag, file_size, output ready);
endinterface

interface sjfq_res_if;
	import sjfq_pkg::*;
	logic               valid;
	logic               ready;
	logic               accepted;
	logic [TAG_W-1:0]   out_tag;
	logic [SIZE_W-1:0]  out_size;
	logic [COUNT_W-1:0] entry_count;
	modport source(output valid, accepted, out_tag, out_size, entry_count, input ready);
	modport sink(input valid, accepted, out_tag, out_size, entry_count, output ready);
endinterface

FILE: hw/rtl/sjfq_cell.sv
// One queue slot: holds an entry, compares it to the incoming size, shifts with neighbors.
module sjfq_cell (
	input  logic               clk,
	input  sjfq_pkg::cell_ctl_t ctl,
	input  logic               slot_valid,
	input  logic               suffix_le,
	input  logic               prev_suffix_le,
	input  sjfq_pkg::entry_t   prev_entry,
	input  sjfq_pkg::entry_t   next_entry,
	output sjfq_pkg::entry_t   entry,
	output logic               le
);
	import sjfq_pkg::*;

	entry_t   entry_q;
	cell_op_t op;

	assign entry = entry_q;
	// In FIFO mode every occupied slot counts as "not larger", so the insert lands at the tail.
	assign le = slot_valid && (ctl.policy == POLICY_FIFO || entry_q.size <= ctl.item.size);

	always_comb begin
		op = OP_HOLD;
		if (ctl.enq) begin
			if (suffix_le) begin
				op = OP_HOLD;
			end else if (prev_suffix_le) begin
				op = OP_LOAD;
			end else begin
				op = OP_BACK;
			end
		end else if (ctl.deq) begin
			op = OP_FWD;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_HOLD: entry_q <= entry_q;
			OP_LOAD: entry_q <= ctl.item;
			OP_BACK: entry_q <= prev_entry;
			OP_FWD:  entry_q <= next_entry;
			default: entry_q <= entry_q;
		endcase
	end

endmodule

FILE: hw/rtl/fifo_or_smallest_first_request_queue_core.sv
// Shortest-job-first request queue: a chain of DEPTH slot cells with count and result register.
//
// Usage:
//  req  (sink): kind 0 enqueues request_tag/file_size, kind 1 dequeues the head.
//  res  (source): one result per request: accepted, out_tag, out_size and the
//       entry count after the request.
//  cfg_we/cfg_wdata: writes the policy bit (0 FIFO, 1 smallest file size first).
//       Write only while no request is in flight.
// Timing:
//  A request is taken on a valid/ready handshake; its result sits in the result
//  register in the next cycle. One request per cycle is sustained while res.ready
//  is high: all slots compare against the new size in parallel and shift in the
//  same cycle, so the rate is set by that compare and suffix-OR across the cell chain.
// Stall: req.ready stays high while the result register is empty or being
//  drained; if res.ready is low with a result waiting, req.ready drops.
// Reset: arst_n clears the count, the policy (FIFO) and the result valid.
//  Slot contents are not cleared; only occupied slots are ever read.
// An enqueue into a full queue and a dequeue from an empty one return
//  accepted=0 with zero tag and size and leave the queue unchanged.
module fifo_or_smallest_first_request_queue_core #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sjfq_req_if.sink   req,
	sjfq_res_if.source res,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import sjfq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic          policy_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] occ_next;
	logic          full;
	logic          empty;
	logic          req_fire;
	logic          enq_ok;
	logic          deq_ok;

	logic               res_valid_q;
	logic               accepted_q;
	tag_t               out_tag_q;
	fsize_t             out_size_q;
	logic [COUNT_W-1:0] count_q;
	logic [CW+COUNT_W-1:0] count_ext;

	cell_ctl_t          ctl;
	entry_t             entries [DEPTH];
	logic [DEPTH-1:0]   le_vec;
	logic [DEPTH-1:0]   suffix;

	assign full     = occ_q == CW'(DEPTH);
	assign empty    = occ_q == '0;
	assign req.ready = !res_valid_q || res.ready;
	assign req_fire = req.valid && req.ready;
	assign enq_ok   = req_fire && req.kind == KIND_ENQ && !full;
	assign deq_ok   = req_fire && req.kind == KIND_DEQ && !empty;

	always_comb begin
		occ_next = occ_q;
		if (enq_ok) begin
			occ_next = occ_q + CW'(1);
		end else if (deq_ok) begin
			occ_next = occ_q - CW'(1);
		end
	end

	assign count_ext = {{COUNT_W{1'b0}}, occ_next};

	assign ctl.enq       = enq_ok;
	assign ctl.deq       = deq_ok;
	assign ctl.policy    = policy_q;
	assign ctl.item.tag  = req.request_tag;
	assign ctl.item.size = req.file_size;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			// suffix[g]: some occupied slot at or after g is not larger than the new size
			assign suffix[g] = |le_vec[DEPTH-1:g];

			logic   prev_s;
			entry_t prev_e;
			entry_t next_e;

			if (g == 0) begin : g_first
				assign prev_s = 1'b1;
				assign prev_e = entries[0];
			end else begin : g_mid
				assign prev_s = suffix[g-1];
				assign prev_e = entries[g-1];
			end

			if (g == DEPTH - 1) begin : g_last
				assign next_e = entries[g];
			end else begin : g_notlast
				assign next_e = entries[g+1];
			end

			sjfq_cell u_cell (
				.clk            (clk),
				.ctl            (ctl),
				.slot_valid     (CW'(g) < occ_q),
				.suffix_le      (suffix[g]),
				.prev_suffix_le (prev_s),
				.prev_entry     (prev_e),
				.next_entry     (next_e),
				.entry          (entries[g]),
				.le             (le_vec[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POLICY_FIFO;
			occ_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			occ_q <= occ_next;
			if (req_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			accepted_q <= enq_ok || deq_ok;
			out_tag_q  <= deq_ok ? entries[0].tag : '0;
			out_size_q <= deq_ok ? entries[0].size : '0;
			count_q    <= count_ext[COUNT_W-1:0];
		end
	end

	assign res.valid       = res_valid_q;
	assign res.accepted    = accepted_q;
	assign res.out_tag     = out_tag_q;
	assign res.out_size    = out_size_q;
	assign res.entry_count = count_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above DEPTH");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |-> !req.ready)
		else $error("request taken while result stalled");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req.kind == KIND_ENQ && full |=> !accepted_q && occ_q == CW'(DEPTH))
		else $error("enqueue into full queue not rejected");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		deq_ok |=> occ_q == $past(occ_q) - CW'(1))
		else $error("dequeue did not decrement count");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		enq_ok |=> accepted_q && occ_q == $past(occ_q) + CW'(1))
		else $error("enqueue did not increment count");

endmodule
